FILE: hw/rtl/lvps_pkg.sv
// ----------------------------------------------------------------------------
// lvps_pkg
// Types and constants shared by the longest valid parentheses stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lvps_pkg;

    localparam int MAX_LEN = 4096;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int LEN_W   = 13;
    localparam int CMP_W   = (POS_W > LEN_W) ? POS_W : LEN_W;
    localparam int LEN_LIMIT = (1 << LEN_W) - 1;

    localparam logic [7:0] OPEN_CODE  = 8'd40;
    localparam logic [7:0] CLOSE_CODE = 8'd41;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } in_t;

    typedef struct packed {
        logic [LEN_W-1:0] run_length;
        logic             overflow;
    } out_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pos;
        logic              is_open;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic fire;
        out_t data;
    } rslt_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lvps_ram.sv
// ----------------------------------------------------------------------------
// lvps_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lvps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lvps_stack_ctl.sv
// ----------------------------------------------------------------------------
// lvps_stack_ctl
// Barrier stack control: cached top and next entries, RAM refill on pop,
// run length tracking and end of string result.
// ----------------------------------------------------------------------------
`default_nettype none

module lvps_stack_ctl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire lvps_pkg::in_t                 in_data,
    input  wire logic [lvps_pkg::ENTRY_W-1:0]  ram_rdata,
    output lvps_pkg::ram_req_t                 ram_req,
    output lvps_pkg::rslt_t                    rslt
);

    logic [lvps_pkg::POS_W-1:0]  depth_reg, depth_next;
    logic [lvps_pkg::POS_W-1:0]  position_reg, position_next;
    logic [lvps_pkg::LEN_W-1:0]  best_reg, best_next;
    logic                        ovf_reg, ovf_next;
    logic                        pending_reg, pending_next;
    lvps_pkg::entry_t            top_reg, top_next;
    lvps_pkg::entry_t            below_reg, below_next;

    lvps_pkg::entry_t            below_cur;
    logic                        ovf_hit;
    logic                        is_pop;
    logic                        is_push;
    logic [lvps_pkg::ADDR_W-1:0] cur_pos;
    logic [lvps_pkg::POS_W-1:0]  depth_dec;
    logic [lvps_pkg::POS_W-1:0]  depth_sub3;
    logic [lvps_pkg::POS_W-1:0]  run;
    logic [lvps_pkg::CMP_W-1:0]  run_wide;
    logic [lvps_pkg::LEN_W-1:0]  run_sat;
    logic [lvps_pkg::LEN_W-1:0]  best_cand;

    always_comb
    begin
        below_cur = pending_reg ? lvps_pkg::entry_t'(ram_rdata) : below_reg;
        ovf_hit   = position_reg >= lvps_pkg::POS_W'(lvps_pkg::MAX_LEN);
        cur_pos   = position_reg[lvps_pkg::ADDR_W-1:0];
        depth_dec = depth_reg - lvps_pkg::POS_W'(1);
        depth_sub3 = depth_reg - lvps_pkg::POS_W'(3);

        is_pop  = !ovf_hit && (in_data.char_code == lvps_pkg::CLOSE_CODE)
                  && (depth_reg != '0) && top_reg.is_open;
        is_push = !ovf_hit && !is_pop
                  && (depth_reg < lvps_pkg::POS_W'(lvps_pkg::MAX_LEN));

        // distance to new top, or to the sentinel at -1
        if (depth_dec == '0)
        begin
            run = position_reg + lvps_pkg::POS_W'(1);
        end
        else
        begin
            run = lvps_pkg::POS_W'(cur_pos - below_cur.pos);
        end
        run_wide = lvps_pkg::CMP_W'(run);
        if (run_wide > lvps_pkg::CMP_W'(lvps_pkg::LEN_LIMIT))
        begin
            run_sat = lvps_pkg::LEN_W'(lvps_pkg::LEN_LIMIT);
        end
        else
        begin
            run_sat = run_wide[lvps_pkg::LEN_W-1:0];
        end
        best_cand = (is_pop && (run_sat > best_reg)) ? run_sat : best_reg;

        ram_req.we    = accept && is_push;
        ram_req.waddr = depth_reg[lvps_pkg::ADDR_W-1:0];
        ram_req.wdata = '{pos: cur_pos,
                          is_open: (in_data.char_code == lvps_pkg::OPEN_CODE)};
        ram_req.re    = accept && is_pop;
        ram_req.raddr = depth_sub3[lvps_pkg::ADDR_W-1:0];

        rslt.fire            = accept && in_data.is_last;
        rslt.data.run_length = best_cand;
        rslt.data.overflow   = ovf_reg || ovf_hit;

        depth_next    = depth_reg;
        position_next = position_reg;
        best_next     = best_reg;
        ovf_next      = ovf_reg;
        pending_next  = 1'b0;
        top_next      = top_reg;
        below_next    = below_cur;

        if (accept)
        begin
            if (in_data.is_last)
            begin
                depth_next    = '0;
                position_next = '0;
                best_next     = '0;
                ovf_next      = 1'b0;
            end
            else if (ovf_hit)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                position_next = position_reg + lvps_pkg::POS_W'(1);
                best_next     = best_cand;
                if (is_pop)
                begin
                    depth_next   = depth_dec;
                    top_next     = below_cur;
                    pending_next = 1'b1;
                end
                else if (is_push)
                begin
                    depth_next = depth_reg + lvps_pkg::POS_W'(1);
                    top_next   = ram_req.wdata;
                    below_next = top_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg    <= '0;
            position_reg <= '0;
            best_reg     <= '0;
            ovf_reg      <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            depth_reg    <= depth_next;
            position_reg <= position_next;
            best_reg     <= best_next;
            ovf_reg      <= ovf_next;
            pending_reg  <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        below_reg <= below_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/longest_valid_parens_stack_unit.sv
// ----------------------------------------------------------------------------
// longest_valid_parens_stack_unit
// Longest well-formed parenthesis run over a character stream, with the
// barrier stack held in a RAM and the two top entries cached in registers.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the request marked last
// throughput: one request per cycle (a last request stalls on a held result);
//   a pop's RAM read data refills the cached entry for the following request
// reset: clears depth, position, best length and overflow; the stack RAM is
//   not cleared, entries above the depth are never used
`default_nettype none

module longest_valid_parens_stack_unit (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire lvps_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output lvps_pkg::out_t      out_data
);

    logic                             accept;
    lvps_pkg::ram_req_t               ram_req;
    logic [lvps_pkg::ENTRY_W-1:0]     ram_rdata;
    lvps_pkg::rslt_t                  rslt;

    logic                             out_valid_reg, out_valid_next;
    lvps_pkg::out_t                   out_data_reg, out_data_next;

    // only a last request needs the result slot
    assign in_stall = out_valid_reg && out_stall && in_data.is_last;
    assign accept   = in_valid && !in_stall;

    lvps_stack_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .ram_rdata (ram_rdata),
        .ram_req   (ram_req),
        .rslt      (rslt)
    );

    lvps_ram #(
        .WIDTH (lvps_pkg::ENTRY_W),
        .DEPTH (lvps_pkg::MAX_LEN)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (rslt.fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = rslt.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire
